### sv/pd_pkg.sv
`default_nettype none

package pd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int MAX_WORDS = 3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    typedef struct packed {
        logic [1:0]                 cnt;
        t_word [MAX_WORDS-1:0]      words;
    } t_push;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c[3:0];
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/pd_front.sv
`default_nettype none

module pd_front import pd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_space_ok,
    output logic            o_ready,
    output t_push           o_push
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;

    assign o_ready = i_space_ok;
    assign accept  = i_valid && i_space_ok;

    always_comb begin
        t_word [MAX_WORDS-1:0] w;
        logic [1:0]            cnt;
        logic                  do_fresh;
        w        = '0;
        cnt      = 2'd0;
        do_fresh = 1'b0;
        n_phase  = r_phase;
        n_held   = r_held;
        unique case (r_phase)
            PH_PCT: begin
                if (is_hex(i_byte)) begin
                    if (i_last) begin
                        w[cnt] = '{data: PCT_CHAR, last: 1'b0};
                        cnt    = cnt + 2'd1;
                        w[cnt] = '{data: i_byte, last: 1'b1};
                        cnt    = cnt + 2'd1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_held  = i_byte;
                        n_phase = PH_DIGIT;
                    end
                end else begin
                    w[cnt]   = '{data: PCT_CHAR, last: 1'b0};
                    cnt      = cnt + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (is_hex(i_byte)) begin
                    w[cnt]  = '{data: {hex_val(r_held), hex_val(i_byte)}, last: i_last};
                    cnt     = cnt + 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    w[cnt]   = '{data: PCT_CHAR, last: 1'b0};
                    cnt      = cnt + 2'd1;
                    w[cnt]   = '{data: r_held, last: 1'b0};
                    cnt      = cnt + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase
        if (do_fresh) begin
            if (i_byte == PCT_CHAR) begin
                if (i_last) begin
                    w[cnt]  = '{data: PCT_CHAR, last: 1'b1};
                    cnt     = cnt + 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_PCT;
                end
            end else begin
                w[cnt]  = '{data: i_byte, last: i_last};
                cnt     = cnt + 2'd1;
                n_phase = PH_IDLE;
            end
        end
        if (i_last) begin
            n_phase = PH_IDLE;
        end
        o_push.words = w;
        o_push.cnt   = accept ? cnt : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

### sv/pd_queue.sv
`default_nettype none

module pd_queue import pd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_push      i_push,
    output logic            o_space_ok,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last,
    input  wire logic       i_ready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_word          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           r_out_valid;
    t_word          r_out;
    logic           pop;

    assign pop        = (r_count != '0) && (!r_out_valid || i_ready);
    assign o_space_ok = r_count <= CW'(DEPTH - MAX_WORDS);
    assign o_valid    = r_out_valid;
    assign o_byte     = r_out.data;
    assign o_last     = r_out.last;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_WORDS; k++) begin
            if (k < int'(i_push.cnt)) begin
                r_mem[r_wr + AW'(k)] <= i_push.words[k];
            end
        end
        if (pop) begin
            r_out <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr    <= r_wr + AW'(i_push.cnt);
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
            if (pop) begin
                r_rd        <= r_rd + AW'(1);
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### sv/percent_decoder.sv
// Channel | Direction | Handshake                  | Word
// input   | in        | i_in_valid / o_in_ready    | i_in_byte, i_in_last
// output  | out       | o_out_valid / i_out_ready  | o_out_byte, o_out_last
// The front takes one word per cycle and pushes zero to three decoded words into the queue.
// Results leave through the output register at one word per cycle while i_out_ready is high.
// The front stalls while the queue has fewer than three free entries. The user must keep DEPTH
// a power of two; the block itself does not enforce it. Synchronous active-low reset clears
// the decode phase, the queue pointers and output valid.
`default_nettype none

module percent_decoder import pd_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    t_push push;
    logic  space_ok;

    pd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .i_space_ok (space_ok),
        .o_ready    (o_in_ready),
        .o_push     (push)
    );

    pd_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_out_valid),
        .o_byte     (o_out_byte),
        .o_last     (o_out_last),
        .i_ready    (i_out_ready)
    );

endmodule

`default_nettype wire

### sv/pd_checker.sv
`default_nettype none

module pd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [7:0] i_in_byte,
    input wire logic       i_in_last,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_out_last
);

    logic [15:0] r_bal;
    logic [7:0]  r_last_bal;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal      <= '0;
            r_last_bal <= '0;
        end else begin
            r_bal      <= r_bal + 16'(in_acc) - 16'(out_acc);
            r_last_bal <= r_last_bal + 8'(in_acc && i_in_last) - 8'(out_acc && o_out_last);
        end
    end

    // A decoded stream never yields more words than it consumed.
    a_out_le_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_bal != 16'd0))
        else $error("output word without a consumed input word");

    // Every end-of-stream mark on the output traces back to one on the input.
    a_last_le_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_last) |-> (r_last_bal != 8'd0))
        else $error("end-of-stream mark without a marked input word");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_out_last)))
        else $error("stalled output word changed");

endmodule

bind percent_decoder pd_checker u_chk (.*);

`default_nettype wire

### verif/tb_percent_decoder.sv
`default_nettype none

module tb_percent_decoder;
    import pd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    percent_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [7:0]  b;
        logic        l;
        logic        typed;
        logic [1:0]  n;
        logic [23:0] ebytes;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    // Rows with typed set carry their decoded words, first word in the top byte.
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000},
        '{8'hFF, 1'b1, 1'b1, 2'd1, 24'hFF0000},
        '{8'h25, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{8'h46, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{8'h30, 1'b1, 1'b1, 2'd1, 24'hF00000},
        '{8'h25, 1'b1, 1'b1, 2'd1, 24'h250000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h39, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h41, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h61, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h47, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h43, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h40, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h2F, 1'b1, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h42, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h3A, 1'b1, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b1, 1'b0, 2'd0, 24'h000000},
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h39, 1'b1, 1'b0, 2'd0, 24'h000000}
    };

    localparam logic [7:0] EDGE_CHARS [12] = '{
        8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41,
        8'h46, 8'h47, 8'h60, 8'h61, 8'h66, 8'h67
    };

    t_word      pending_words[$];
    t_word      step_words[$];
    t_phase     dec_phase = PH_IDLE;
    logic [7:0] dec_held  = 8'h00;
    int         errors     = 0;
    int         send_idle  = 0;
    int         recv_stall = 0;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 20) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    function automatic logic is_upper_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46]};
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        return (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
    endfunction

    task automatic emit(input logic [7:0] b, input logic l);
        step_words.push_back(t_word'({b, l}));
    endtask

    task automatic decode_fresh(input logic [7:0] b, input logic l);
        if (b == PCT_CHAR && !l) begin
            dec_phase = PH_PCT;
        end else begin
            emit(b, l);
            dec_phase = PH_IDLE;
        end
    endtask

    task automatic decode_step(input logic [7:0] b, input logic l);
        step_words.delete();
        case (dec_phase)
            PH_PCT: begin
                if (is_upper_hex(b)) begin
                    if (l) begin
                        emit(PCT_CHAR, 1'b0);
                        emit(b, 1'b1);
                    end else begin
                        dec_held  = b;
                        dec_phase = PH_DIGIT;
                    end
                end else begin
                    emit(PCT_CHAR, 1'b0);
                    decode_fresh(b, l);
                end
            end
            PH_DIGIT: begin
                if (is_upper_hex(b)) begin
                    emit({nibble_of(dec_held), nibble_of(b)}, l);
                    dec_phase = PH_IDLE;
                end else begin
                    emit(PCT_CHAR, 1'b0);
                    emit(dec_held, 1'b0);
                    decode_fresh(b, l);
                end
                dec_held = 8'h00;
            end
            default: decode_fresh(b, l);
        endcase
        if (l) begin
            dec_phase = PH_IDLE;
            dec_held  = 8'h00;
        end
    endtask

    task automatic feed(input logic [7:0] b, input logic l, input logic typed,
                        input logic [1:0] n, input logic [23:0] ebytes);
        int j;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_step(b, l);
        if (typed) begin
            for (j = 0; j < n; j++) begin
                pending_words.push_back(t_word'({ebytes[23 - 8*j -: 8], (j == n - 1) && l}));
            end
        end else begin
            foreach (step_words[j]) pending_words.push_back(step_words[j]);
        end
    endtask

    task automatic feed_random(input int count);
        logic [7:0] tok[$];
        int         left;
        int         r;
        left = count;
        while (left > 0) begin
            r = $urandom_range(99);
            tok.delete();
            if (r < 55) begin
                tok = '{PCT_CHAR, rand_hex_char(), rand_hex_char()};
            end else if (r < 70) begin
                tok = '{8'($urandom_range(255))};
            end else if (r < 80) begin
                tok = '{PCT_CHAR, rand_hex_char(), 8'($urandom_range(255))};
            end else if (r < 88) begin
                tok = '{PCT_CHAR, 8'($urandom_range(255))};
            end else if (r < 94) begin
                tok = '{PCT_CHAR, EDGE_CHARS[$urandom_range(11)]};
            end else begin
                tok = '{PCT_CHAR, PCT_CHAR};
            end
            while (tok.size() != 0 && left > 0) begin
                feed(tok.pop_front(), $urandom_range(11) == 0, 1'b0, 2'd0, 24'h0);
                left--;
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin : out_check
        t_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h last %b", o_out_byte, o_out_last));
            end else begin
                want = pending_words.pop_front();
                if (o_out_byte !== want.data) begin
                    report_mismatch($sformatf("byte %h, expected %h", o_out_byte, want.data));
                end
                if (o_out_last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b on byte %h",
                                              o_out_last, want.last, want.data));
                end
            end
        end
    end

    initial begin : stimulus
        int k;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < DIR_ROWS; k++) begin
            feed(DIR_TAB[k].b, DIR_TAB[k].l, DIR_TAB[k].typed, DIR_TAB[k].n,
                 DIR_TAB[k].ebytes);
        end
        feed_random(80);
        send_idle = 59;
        feed_random(80);
        send_idle  = 0;
        recv_stall = 59;
        feed_random(80);
        send_idle  = 34;
        recv_stall = 34;
        feed_random(80);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/pd_pkg.sv
sv/pd_front.sv
sv/pd_queue.sv
sv/percent_decoder.sv
sv/pd_checker.sv
verif/tb_percent_decoder.sv
